[hdl/sqns_pkg.sv]
`timescale 1ns / 1ps

package sqns_pkg;

    // item kinds
    localparam logic KindWrite = 1'b0;
    localparam logic KindTick  = 1'b1;

    // register addresses
    localparam logic [3:0] AddrStep0  = 4'd10;
    localparam logic [3:0] AddrStep3  = 4'd13;
    localparam logic [3:0] AddrVolume = 4'd14;

    // reset values and constants
    localparam logic [15:0] ScaleReset  = 16'd6434;
    localparam logic [22:0] NoiseSeed   = 23'h7ffff8;
    localparam logic [15:0] FreqBase    = 16'd65535;
    localparam logic [6:0]  DivFallback = 7'd127;
    localparam int          DivBits     = 18;
    localparam logic [12:0] MixCenter   = 13'd2048;

    // controller to datapath commands
    typedef struct packed {
        logic load_div;
        logic wr_vol;
        logic div_step;
        logic wr_step;
        logic tick_acc;
        logic tick_mix;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic out_free;
    } t_status;

    // shift the noise register left by n places (0..16), feedback bit22 ^ bit17
    function automatic logic [22:0] noise_shift(input logic [22:0] v, input logic [4:0] n);
        logic [22:0] r;
        int          k;
        r = '0;
        k = int'(n);
        for (int j = 0; j < 23; j++) begin
            if (j >= k) begin
                r[j] = v[j - k];
            end else begin
                r[j] = v[j + 23 - k] ^ v[j + 18 - k];
            end
        end
        return r;
    endfunction

    // eight taps of the noise register
    function automatic logic [7:0] noise_taps(input logic [22:0] v);
        return {v[22], v[20], v[16], v[13], v[11], v[7], v[4], v[2]};
    endfunction

endpackage

[hdl/sqns_in_if.sv]
`timescale 1ns / 1ps

interface sqns_in_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [3:0] reg_addr;
    logic [7:0] reg_value;

    modport source (output valid, output kind, output reg_addr, output reg_value,
                    input ready);
    modport sink   (input valid, input kind, input reg_addr, input reg_value,
                    output ready);
endinterface

[hdl/sqns_out_if.sv]
`timescale 1ns / 1ps

interface sqns_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

[hdl/sqns_ctrl.sv]
`timescale 1ns / 1ps

module sqns_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_kind,
    input  logic [3:0]        i_reg_addr,
    output logic              o_ready,
    input  sqns_pkg::t_status i_status,
    output sqns_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MUL,
        S_ACC,
        S_MIX
    } t_state;

    localparam int CntW = $clog2(sqns_pkg::DivBits);
    localparam logic [CntW-1:0] CntLast = CntW'(sqns_pkg::DivBits - 1);

    t_state          r_state, n_state;
    logic [CntW-1:0] r_cnt, n_cnt;
    logic            w_accept;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_kind == sqns_pkg::KindTick) begin
                        n_state = S_ACC;
                    end else if (i_reg_addr inside {[sqns_pkg::AddrStep0:sqns_pkg::AddrStep3]}) begin
                        o_cmd.load_div = 1'b1;
                        n_cnt          = '0;
                        n_state        = S_DIV;
                    end else if (i_reg_addr == sqns_pkg::AddrVolume) begin
                        o_cmd.wr_vol = 1'b1;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == CntLast) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.wr_step = 1'b1;
                n_state       = S_IDLE;
            end
            S_ACC: begin
                o_cmd.tick_acc = 1'b1;
                n_state        = S_MIX;
            end
            S_MIX: begin
                if (i_status.out_free) begin
                    o_cmd.tick_mix = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

[hdl/sqns_datapath.sv]
`timescale 1ns / 1ps

module sqns_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [15:0]       i_cfg_wr_data,
    input  logic [3:0]        i_reg_addr,
    input  logic [7:0]        i_reg_value,
    input  sqns_pkg::t_cmd    i_cmd,
    output sqns_pkg::t_status o_status,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [15:0]       o_sample
);

    localparam int QW = sqns_pkg::DivBits;

    logic [15:0]       r_scale;
    logic [31:0]       r_step [4];
    logic [31:0]       r_acc  [4];
    logic [22:0]       r_noise;
    logic [3:0]        r_vol;
    logic [QW-1:0]     r_quo;
    logic [6:0]        r_rem;
    logic [6:0]        r_div;
    logic [1:0]        r_voice;
    logic              r_out_valid;
    logic [15:0]       r_sample;

    logic [1:0]        w_voice;
    logic [1:0]        w_shift;
    logic [6:0]        w_div_raw;
    logic [QW-1:0]     w_num;
    logic [7:0]        w_trial;
    logic              w_fits;
    logic [33:0]       w_prod;
    logic [32:0]       w_acc3_sum;
    logic [22:0]       w_tap_src;
    logic [11:0]       w_mix;
    logic signed [12:0] w_centered;
    logic signed [17:0] w_scaled;

    // divider operand setup on a step write
    assign w_voice   = 2'(i_reg_addr - sqns_pkg::AddrStep0);
    assign w_shift   = (w_voice == 2'd3) ? 2'd0 : w_voice;
    assign w_div_raw = ~i_reg_value[6:0];
    assign w_num     = i_reg_value[7] ? (QW'(sqns_pkg::FreqBase) << w_shift) : '0;

    // restoring divider step
    assign w_trial = {r_rem, r_quo[QW-1]};
    assign w_fits  = (w_trial >= {1'b0, r_div});

    // step = scale * quotient, low 32 bits kept
    assign w_prod = r_scale * r_quo;

    // noise voice carry
    assign w_acc3_sum = {1'b0, r_acc[3]} + {1'b0, r_step[3]};

    // mix of squares and noise taps
    assign w_tap_src  = sqns_pkg::noise_shift(r_noise, {1'b0, r_acc[3][31:28]});
    assign w_mix      = {1'b0, 2'(r_acc[0][31]) + 2'(r_acc[1][31]) + 2'(r_acc[2][31]), 9'd0}
                      + {2'b00, sqns_pkg::noise_taps(w_tap_src), 2'b00};
    assign w_centered = $signed({1'b0, w_mix}) - $signed(sqns_pkg::MixCenter);
    assign w_scaled   = w_centered * $signed({1'b0, r_vol});

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_sample          = r_sample;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= sqns_pkg::ScaleReset;
            r_noise     <= sqns_pkg::NoiseSeed;
            r_vol       <= '0;
            r_out_valid <= 1'b0;
            for (int v = 0; v < 4; v++) begin
                r_step[v] <= '0;
                r_acc[v]  <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_scale <= i_cfg_wr_data;
            end
            if (i_cmd.wr_vol) begin
                r_vol <= i_reg_value[3:0];
            end
            if (i_cmd.wr_step) begin
                r_step[r_voice] <= w_prod[31:0];
            end
            if (i_cmd.tick_acc) begin
                for (int v = 0; v < 4; v++) begin
                    r_acc[v] <= r_acc[v] + r_step[v];
                end
                if (w_acc3_sum[32]) begin
                    r_noise <= sqns_pkg::noise_shift(r_noise, 5'd16);
                end
            end
            // output beat register
            if (i_cmd.tick_mix) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // divider and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_div) begin
            r_quo   <= w_num;
            r_rem   <= '0;
            r_div   <= (w_div_raw == '0) ? sqns_pkg::DivFallback : w_div_raw;
            r_voice <= w_voice;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[QW-2:0], w_fits};
            r_rem <= w_fits ? 7'(w_trial - {1'b0, r_div}) : w_trial[6:0];
        end
        if (i_cmd.tick_mix) begin
            r_sample <= w_scaled[15:0];
        end
    end

    // a new sample never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tick_mix |-> (!r_out_valid || i_out_ready))
        else $error("sample overwritten while output beat pending");

    // partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_div || i_cmd.div_step) |=> (r_rem < r_div))
        else $error("divider remainder out of range");

    // accumulator advances by its step on a tick
    a_acc_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.tick_acc |=> (r_acc[0] == 32'($past(r_acc[0]) + $past(r_step[0]))))
        else $error("phase accumulator did not advance");

    // division and tick work never overlap
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({i_cmd.load_div, i_cmd.div_step, i_cmd.wr_step,
                  i_cmd.tick_acc, i_cmd.tick_mix}))
        else $error("conflicting datapath commands");

endmodule

[hdl/square_noise_sound_generator.sv]
`timescale 1ns / 1ps
// a tick is accumulated, then mixed into the output register once the output register is free
// a step write runs an operand load, 18 restoring divider steps, then one multiply
// volume and ignored writes finish on acceptance; one item is in work at a time
// input ready is high only in the idle state, so a new item waits until the last one is done
// reset: synchronous active low, clears steps, accumulators, volume, noise to its seed

module square_noise_sound_generator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    sqns_in_if.sink     i_in,
    sqns_out_if.source  o_out
);

    sqns_pkg::t_cmd    w_cmd;
    sqns_pkg::t_status w_status;
    logic [15:0]       w_sample;

    // sequencing
    sqns_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_in.valid),
        .i_kind     (i_in.kind),
        .i_reg_addr (i_in.reg_addr),
        .o_ready    (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // voices, divider and mixer
    sqns_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_reg_addr    (i_in.reg_addr),
        .i_reg_value   (i_in.reg_value),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_out_valid   (o_out.valid),
        .i_out_ready   (o_out.ready),
        .o_sample      (w_sample)
    );

    assign o_out.sample = $signed(w_sample);

endmodule

[tb/tb_square_noise_sound_generator.sv]
`timescale 1ns / 1ps

module tb_square_noise_sound_generator;

    localparam int CLK_HALF    = 10;
    localparam int RESET_CYC   = 9;
    localparam int SETTLE_CYC  = 30;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYC    = 400;
    localparam int IDLE_PCT    = 27;

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;

    sqns_in_if  in_bus ();
    sqns_out_if out_bus ();

    square_noise_sound_generator u_top (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_in          (in_bus),
        .o_out         (out_bus)
    );

    // shadow of the generator state
    logic [15:0] step_scale;
    logic [31:0] voice_phase [4];
    logic [31:0] voice_step [4];
    logic [22:0] noise_reg;
    logic [3:0]  volume;

    logic signed [15:0] expected_samples [$];
    logic signed [15:0] want_sample;

    int  err_count;
    bit  tx_idle_on;
    bit  rx_idle_on;
    int  rx_hold_req;
    int  rx_hold_left;
    int  stall_cycles;

    // clock
    initial begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // noise register advanced by n places at once, feedback taken from the old value
    function automatic logic [22:0] noise_advance(input logic [22:0] v, input int unsigned n);
        logic [31:0] wide;
        logic [31:0] fb;
        if (n == 0) begin
            return v;
        end
        wide = {9'd0, v};
        fb   = (wide >> (23 - n)) ^ (wide >> (18 - n));
        wide = (wide << n) | (fb & ((32'd1 << n) - 32'd1));
        return wide[22:0];
    endfunction

    // noise register bits that feed the mix, msb first
    function automatic logic [7:0] noise_mix_bits(input logic [22:0] v);
        return {v[22], v[20], v[16], v[13], v[11], v[7], v[4], v[2]};
    endfunction

    // step of one voice for a written byte
    function automatic logic [31:0] voice_step_for(input int unsigned voice,
                                                  input logic [7:0] value);
        logic [7:0]  divisor;
        logic [31:0] quot;
        logic [47:0] prod;
        int unsigned shift;
        if (!value[7]) begin
            return 32'd0;
        end
        shift   = (voice == 3) ? 0 : voice;
        divisor = 8'd255 - value;
        if (divisor == 8'd0) begin
            divisor = {1'b0, sqns_pkg::DivFallback};
        end
        quot = (32'(sqns_pkg::FreqBase) << shift) / 32'(divisor);
        prod = 48'(step_scale) * 48'(quot);
        return prod[31:0];
    endfunction

    // apply one accepted beat to the shadow state, queue a sample for a tick
    task automatic update_voices(input logic k, input logic [3:0] a, input logic [7:0] v);
        int          squares;
        int          mix;
        logic [31:0] prod;
        logic [7:0]  taps;
        if (k == sqns_pkg::KindWrite) begin
            if (a >= sqns_pkg::AddrStep0 && a <= sqns_pkg::AddrStep3) begin
                voice_step[a - sqns_pkg::AddrStep0] =
                    voice_step_for(a - sqns_pkg::AddrStep0, v);
            end else if (a == sqns_pkg::AddrVolume) begin
                volume = v[3:0];
            end
        end else begin
            for (int i = 0; i < 4; i++) begin
                voice_phase[i] = voice_phase[i] + voice_step[i];
            end
            // noise voice wrapped around
            if (voice_phase[3] < voice_step[3]) begin
                noise_reg = noise_advance(noise_reg, 16);
            end
            squares = 0;
            for (int i = 0; i < 3; i++) begin
                squares += voice_phase[i][31];
            end
            taps = noise_mix_bits(noise_advance(noise_reg, voice_phase[3][31:28]));
            mix  = squares * 512 + int'(taps) * 4 - int'(sqns_pkg::MixCenter);
            prod = 32'(mix * int'(volume));
            expected_samples.push_back(prod[15:0]);
        end
    endtask

    // one input beat, with random idle cycles ahead of it
    task automatic send_beat(input logic k, input logic [3:0] a, input logic [7:0] v);
        int gap;
        gap = 0;
        while (tx_idle_on && $urandom_range(0, 99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.kind      <= k;
        in_bus.reg_addr  <= a;
        in_bus.reg_value <= v;
        @(posedge clk);
        while (!in_bus.ready) @(posedge clk);
        update_voices(k, a, v);
    endtask

    task automatic send_tick();
        send_beat(sqns_pkg::KindTick, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
    endtask

    // stop offering and wait for every queued sample plus the divider time
    task automatic drain_samples();
        in_bus.valid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_scale(input logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        step_scale = value;
    endtask

    // mostly ticks between step and volume writes, some stray addresses
    task automatic run_random(input int n_items);
        int         sent;
        int         r;
        logic       k;
        logic [3:0] a;
        logic [7:0] v;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            k = sqns_pkg::KindWrite;
            a = 4'($urandom_range(0, 15));
            v = 8'($urandom_range(0, 255));
            if (r < 55) begin
                k = sqns_pkg::KindTick;
            end else if (r < 75) begin
                a = sqns_pkg::AddrStep0 + 4'($urandom_range(0, 3));
                if ($urandom_range(0, 99) < 80) begin
                    v[7] = 1'b1;
                end
            end else if (r < 85) begin
                a = sqns_pkg::AddrVolume;
            end
            send_beat(k, a, v);
            sent++;
        end
    endtask

    // field extremes, both step encodings, stray addresses, volume range
    task automatic test_directed();
        send_beat(sqns_pkg::KindWrite, sqns_pkg::AddrVolume, 8'h0f);
        send_tick();
        send_beat(sqns_pkg::KindWrite, sqns_pkg::AddrStep0, 8'hff);
        send_beat(sqns_pkg::KindWrite, sqns_pkg::AddrStep0 + 4'd1, 8'h80);
        send_beat(sqns_pkg::KindWrite, sqns_pkg::AddrStep0 + 4'd2, 8'hfe);
        send_beat(sqns_pkg::KindWrite, sqns_pkg::AddrStep3, 8'hfe);
        repeat (5) send_tick();
        send_beat(sqns_pkg::KindWrite, sqns_pkg::AddrStep0 + 4'd1, 8'h7f);
        send_beat(sqns_pkg::KindWrite, 4'd0, 8'hff);
        send_beat(sqns_pkg::KindWrite, 4'd15, 8'h00);
        send_beat(sqns_pkg::KindWrite, 4'd9, 8'hff);
        send_beat(sqns_pkg::KindWrite, sqns_pkg::AddrStep3, 8'hff);
        repeat (3) send_tick();
        send_beat(sqns_pkg::KindWrite, sqns_pkg::AddrVolume, 8'hf0);
        send_tick();
        send_beat(sqns_pkg::KindWrite, sqns_pkg::AddrVolume, 8'h88);
        repeat (2) send_tick();
        drain_samples();
    endtask

    // scale extremes and a few ordinary values, each followed by random traffic
    task automatic test_scale_sweep();
        logic [15:0] scales [5];
        scales = '{16'd0, 16'hffff, 16'd1, sqns_pkg::ScaleReset,
                   16'($urandom_range(0, 65535))};
        foreach (scales[i]) begin
            write_scale(scales[i]);
            run_random(200);
            drain_samples();
        end
    endtask

    // long stretch with neither side idling
    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        write_scale(16'($urandom_range(1000, 20000)));
        run_random(200);
        drain_samples();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // receiver holds off while ticks keep coming, so the input stalls
    task automatic test_output_stall();
        rx_hold_req = HOLD_CYC;
        repeat (30) send_tick();
        drain_samples();
        run_random(50);
        drain_samples();
    endtask

    // sink side: random idle cycles and the occasional long hold-off
    initial begin
        out_bus.ready <= 1'b0;
        rx_hold_left = 0;
        forever begin
            @(posedge clk);
            if (rx_hold_req > 0) begin
                rx_hold_left = rx_hold_req;
                rx_hold_req  = 0;
            end
            if (rx_hold_left > 0) begin
                out_bus.ready <= 1'b0;
                rx_hold_left--;
            end else begin
                out_bus.ready <= !(rx_idle_on && $urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // compare each output beat with the oldest expected sample
    always @(posedge clk) begin
        if (rst_n && out_bus.valid && out_bus.ready) begin
            if (expected_samples.size() == 0) begin
                $display("%0t: unexpected sample, expected none actual %0d",
                         $time, out_bus.sample);
                err_count++;
            end else begin
                want_sample = expected_samples.pop_front();
                if (out_bus.sample !== want_sample) begin
                    $display("%0t: sample mismatch, expected %0d actual %0d",
                             $time, want_sample, out_bus.sample);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles with no beat on either side
    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    // main sequence
    initial begin
        err_count   = 0;
        tx_idle_on  = 1'b1;
        rx_idle_on  = 1'b1;
        rx_hold_req = 0;
        step_scale  = sqns_pkg::ScaleReset;
        for (int i = 0; i < 4; i++) begin
            voice_phase[i] = 32'd0;
            voice_step[i]  = 32'd0;
        end
        noise_reg = sqns_pkg::NoiseSeed;
        volume    = 4'd0;

        rst_n            <= 1'b0;
        cfg_wr_en        <= 1'b0;
        cfg_wr_data      <= 16'd0;
        in_bus.valid     <= 1'b0;
        in_bus.kind      <= sqns_pkg::KindWrite;
        in_bus.reg_addr  <= 4'd0;
        in_bus.reg_value <= 8'd0;
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_scale_sweep();
        test_back_to_back();
        test_output_stall();

        drain_samples();
        if (err_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
